### hw/rtl/sbba_pkg.sv
// Shared types and constants for the size-binned block allocator.
// No dependencies; used by sbba_desc_mem, size_binned_block_allocator_top and the testbench.
package sbba_pkg;

    localparam int HANDLE_W     = 12;
    localparam int SIZE_W       = 12;
    localparam int COUNT_W      = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int MAX_BINS     = 6;
    localparam int HANDLE_REACH = 4096;

    localparam logic REQ_ALLOC = 1'b0;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_START = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE  = 3'd7;

    localparam logic [SIZE_W-1:0] BIN_RESET [MAX_BINS] = '{
        12'd1024, 12'd512, 12'd256, 12'd128, 12'd64, 12'd32
    };
    localparam logic [HANDLE_W-1:0] POOL_START_RESET = 12'd4;
    localparam logic [SIZE_W-1:0]   POOL_SIZE_RESET  = 12'd4092;

    typedef enum logic [1:0] {
        STS_OK,
        STS_NO_ROOM,
        STS_BAD_HANDLE
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_DECIDE,
        S_APPLY
    } state_t;

    typedef struct packed {
        logic                req_type;
        logic [SIZE_W-1:0]   req_size;
        logic [HANDLE_W-1:0] free_handle;
    } req_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [HANDLE_W-1:0] block_handle;
        logic [SIZE_W-1:0]   granted_size;
        logic [COUNT_W-1:0]  check_errors;
    } rsp_t;

    typedef struct packed {
        logic                used;
        logic [SIZE_W-1:0]   size;
        logic [HANDLE_W-1:0] next;
    } desc_t;

endpackage

### hw/rtl/sbba_desc_mem.sv
// Single-port descriptor memory with a registered read.
// Depends on sbba_pkg for the descriptor type.
module sbba_desc_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic                 we,
    input  logic [AW-1:0]        addr,
    input  sbba_pkg::desc_t      wdata,
    output sbba_pkg::desc_t      rdata
);

    sbba_pkg::desc_t mem [DEPTH];
    sbba_pkg::desc_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/size_binned_block_allocator_top.sv
// Top level of the size-binned block allocator: request decode, bin choice,
// free stacks and result register. Depends on sbba_pkg and sbba_desc_mem.
//
// Each transaction on req allocates or frees one block of the pool and gives
// one transaction on rsp. A failed allocation, one carved fresh at the fresh
// pointer, and a free rejected on its handle range finish in S_DECIDE once
// the output register is free; a pop from a bin's free stack and every other
// free go on to S_APPLY, because the single-port descriptor memory is read
// first and, on success, written back there. A new request is accepted in the
// cycle a result is produced, and a result may wait in the output register
// while the next request is taken. After reset the descriptor memory is
// cleared one entry a cycle, all POOL_LIMIT/4 entries (1024 at default
// parameters), with req_ready low; configuration writes are taken meanwhile.
module size_binned_block_allocator_top #(
    parameter int NUM_BINS       = 6,
    parameter int POOL_BYTES     = 4096,
    parameter int DESC_BYTES     = 20,
    parameter int VALIDITY_BYTES = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 req_valid,
    output logic                                 req_ready,
    input  sbba_pkg::req_t                       req,
    output logic                                 rsp_valid,
    input  logic                                 rsp_ready,
    output sbba_pkg::rsp_t                       rsp,
    input  logic                                 cfg_we,
    input  logic [sbba_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [sbba_pkg::SIZE_W-1:0]          cfg_wdata
);

    localparam int POOL_LIMIT = (POOL_BYTES < sbba_pkg::HANDLE_REACH) ?
                                POOL_BYTES : sbba_pkg::HANDLE_REACH;
    localparam int DEPTH      = POOL_LIMIT / 4;
    localparam int AW         = $clog2(DEPTH);
    localparam int SPAN       = ((DESC_BYTES + 3) / 4) * 4;
    localparam int BW         = $clog2(NUM_BINS);
    localparam int HW         = sbba_pkg::HANDLE_W;
    localparam int SW         = sbba_pkg::SIZE_W;
    localparam int CW         = sbba_pkg::COUNT_W;

    function automatic logic [AW-1:0] idx(input logic [HW-1:0] h);
        return h[AW+1:2];
    endfunction

    sbba_pkg::state_t       state_reg, state_next;
    sbba_pkg::req_t         req_reg, req_next;
    logic [BW-1:0]          bin_reg, bin_next;
    logic [AW-1:0]          clr_cnt_reg, clr_cnt_next;
    logic [SW-1:0]          bin_size_reg [NUM_BINS];
    logic [SW-1:0]          bin_size_next [NUM_BINS];
    logic [HW-1:0]          pool_start_reg, pool_start_next;
    logic [SW-1:0]          pool_size_reg, pool_size_next;
    logic [HW-1:0]          fresh_reg, fresh_next;
    logic [HW-1:0]          free_top_reg [NUM_BINS];
    logic [HW-1:0]          free_top_next [NUM_BINS];
    logic [CW-1:0]          chk_err_reg, chk_err_next;
    sbba_pkg::rsp_t         rsp_reg, rsp_next;
    logic                   rsp_valid_reg, rsp_valid_next;

    logic                   mem_en;
    logic                   mem_we;
    logic [AW-1:0]          mem_addr;
    sbba_pkg::desc_t        mem_wdata;
    sbba_pkg::desc_t        rd_desc;

    logic                   slot_free;
    logic                   fin;
    logic [SW-1:0]          want;
    logic                   too_big;
    logic [BW-1:0]          pick;
    logic                   run;
    logic [HW-1:0]          top_pick;
    logic [HW-1:0]          top_bin;
    logic [HW:0]            pool_sum;
    logic [HW:0]            pool_end;
    logic                   no_room;
    logic                   bad_range;
    logic [SW-1:0]          cfg_val;
    sbba_pkg::rsp_t         res;

    sbba_desc_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_desc_mem (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (rd_desc)
    );

    always_comb
    begin
        pool_sum = {1'b0, pool_start_reg} + {1'b0, pool_size_reg};
        pool_end = (pool_sum > (HW+1)'(POOL_LIMIT)) ? (HW+1)'(POOL_LIMIT) : pool_sum;

        want    = (state_reg == sbba_pkg::S_APPLY) ? rd_desc.size : req_reg.req_size;
        too_big = want > bin_size_reg[0];
        pick    = '0;
        run     = 1'b1;
        for (int i = 1; i < NUM_BINS; i++)
        begin
            if (run && (want <= bin_size_reg[i]))
            begin
                pick = BW'(i);
            end
            else
            begin
                run = 1'b0;
            end
        end
        top_pick = free_top_reg[pick];
        top_bin  = free_top_reg[bin_reg];

        no_room = (fresh_reg == '0) ||
                  (({2'b00, fresh_reg} + (HW+2)'(SPAN) + {2'b00, bin_size_reg[pick]})
                   >= {1'b0, pool_end});
        bad_range = (req_reg.free_handle[1:0] != 2'b00) ||
                    ({2'b00, req_reg.free_handle} < (HW+2)'(VALIDITY_BYTES)) ||
                    (({2'b00, req_reg.free_handle} + (HW+2)'(SPAN) +
                      {2'b00, bin_size_reg[NUM_BINS-1]} + (HW+2)'(VALIDITY_BYTES))
                     > {1'b0, pool_end});
    end

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        bin_next        = bin_reg;
        clr_cnt_next    = clr_cnt_reg;
        bin_size_next   = bin_size_reg;
        pool_start_next = pool_start_reg;
        pool_size_next  = pool_size_reg;
        fresh_next      = fresh_reg;
        free_top_next   = free_top_reg;
        chk_err_next    = chk_err_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg;
        mem_en          = 1'b0;
        mem_we          = 1'b0;
        mem_addr        = '0;
        mem_wdata       = '0;
        fin             = 1'b0;
        res             = '0;
        slot_free       = !rsp_valid_reg || rsp_ready;
        cfg_val         = {cfg_wdata[SW-1:2], 2'b00};

        unique case (state_reg)
            sbba_pkg::S_CLEAR:
            begin
                mem_en   = 1'b1;
                mem_we   = 1'b1;
                mem_addr = clr_cnt_reg;
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = sbba_pkg::S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            sbba_pkg::S_IDLE:
            begin
                state_next = sbba_pkg::S_IDLE;
            end
            sbba_pkg::S_DECIDE:
            begin
                if (req_reg.req_type == sbba_pkg::REQ_ALLOC)
                begin
                    priority if (too_big)
                    begin
                        fin        = slot_free;
                        res.status = sbba_pkg::STS_NO_ROOM;
                    end
                    else if (top_pick != '0)
                    begin
                        mem_en     = 1'b1;
                        mem_addr   = idx(top_pick);
                        bin_next   = pick;
                        state_next = sbba_pkg::S_APPLY;
                    end
                    else if (no_room)
                    begin
                        fin        = slot_free;
                        res.status = sbba_pkg::STS_NO_ROOM;
                    end
                    else
                    begin
                        fin              = slot_free;
                        res.status       = sbba_pkg::STS_OK;
                        res.block_handle = fresh_reg;
                        res.granted_size = bin_size_reg[pick];
                        if (fin)
                        begin
                            mem_en         = 1'b1;
                            mem_we         = 1'b1;
                            mem_addr       = idx(fresh_reg);
                            mem_wdata.used = 1'b1;
                            mem_wdata.size = bin_size_reg[pick];
                            fresh_next     = fresh_reg + bin_size_reg[pick] + HW'(SPAN);
                        end
                    end
                end
                else
                begin
                    if (bad_range)
                    begin
                        fin        = slot_free;
                        res.status = sbba_pkg::STS_BAD_HANDLE;
                    end
                    else
                    begin
                        mem_en     = 1'b1;
                        mem_addr   = idx(req_reg.free_handle);
                        state_next = sbba_pkg::S_APPLY;
                    end
                end
            end
            sbba_pkg::S_APPLY:
            begin
                fin = slot_free;
                if (req_reg.req_type == sbba_pkg::REQ_ALLOC)
                begin
                    res.status       = sbba_pkg::STS_OK;
                    res.block_handle = top_bin;
                    res.granted_size = bin_size_reg[bin_reg];
                    if (fin)
                    begin
                        mem_en                 = 1'b1;
                        mem_we                 = 1'b1;
                        mem_addr               = idx(top_bin);
                        mem_wdata.used         = 1'b1;
                        mem_wdata.size         = bin_size_reg[bin_reg];
                        free_top_next[bin_reg] = rd_desc.next;
                    end
                end
                else
                begin
                    priority if (!rd_desc.used)
                    begin
                        res.status = sbba_pkg::STS_BAD_HANDLE;
                    end
                    else if (too_big)
                    begin
                        res.status = sbba_pkg::STS_BAD_HANDLE;
                        if (fin && (chk_err_reg != '1))
                        begin
                            chk_err_next = chk_err_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        res.status = sbba_pkg::STS_OK;
                        if (fin)
                        begin
                            mem_en              = 1'b1;
                            mem_we              = 1'b1;
                            mem_addr            = idx(req_reg.free_handle);
                            mem_wdata.used      = 1'b0;
                            mem_wdata.size      = rd_desc.size;
                            mem_wdata.next      = top_pick;
                            free_top_next[pick] = req_reg.free_handle;
                        end
                    end
                end
            end
            default:
            begin
                state_next = sbba_pkg::S_IDLE;
            end
        endcase

        res.check_errors = chk_err_next;
        req_ready        = (state_reg == sbba_pkg::S_IDLE) || fin;

        if (fin)
        begin
            rsp_next       = res;
            rsp_valid_next = 1'b1;
            state_next     = sbba_pkg::S_IDLE;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (req_valid && req_ready)
        begin
            req_next   = req;
            state_next = sbba_pkg::S_DECIDE;
        end

        if (cfg_we)
        begin
            for (int i = 0; i < NUM_BINS; i++)
            begin
                if (cfg_addr == sbba_pkg::CFG_IDX_W'(i))
                begin
                    bin_size_next[i] = cfg_val;
                end
            end
            if (cfg_addr == sbba_pkg::CFG_POOL_START)
            begin
                pool_start_next = cfg_val;
                fresh_next      = cfg_val;
            end
            if (cfg_addr == sbba_pkg::CFG_POOL_SIZE)
            begin
                pool_size_next = cfg_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sbba_pkg::S_CLEAR;
            bin_reg        <= '0;
            clr_cnt_reg    <= '0;
            pool_start_reg <= sbba_pkg::POOL_START_RESET;
            pool_size_reg  <= sbba_pkg::POOL_SIZE_RESET;
            fresh_reg      <= sbba_pkg::POOL_START_RESET;
            chk_err_reg    <= '0;
            rsp_valid_reg  <= 1'b0;
            for (int i = 0; i < NUM_BINS; i++)
            begin
                bin_size_reg[i] <= sbba_pkg::BIN_RESET[i];
                free_top_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            bin_reg        <= bin_next;
            clr_cnt_reg    <= clr_cnt_next;
            pool_start_reg <= pool_start_next;
            pool_size_reg  <= pool_size_next;
            fresh_reg      <= fresh_next;
            chk_err_reg    <= chk_err_next;
            rsp_valid_reg  <= rsp_valid_next;
            bin_size_reg   <= bin_size_next;
            free_top_reg   <= free_top_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTH
    a_clear_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sbba_pkg::S_CLEAR) |-> !req_ready)
        else $error("request accepted during descriptor clear");

    a_write_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_en && mem_we) |-> (fin || (state_reg == sbba_pkg::S_CLEAR)))
        else $error("descriptor written without a finishing transaction");

    a_fail_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_reg.status != sbba_pkg::STS_OK)) |->
        ((rsp_reg.block_handle == '0) && (rsp_reg.granted_size == '0)))
        else $error("failed transaction carries a handle or size");

    a_handle_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_reg.block_handle[1:0] == 2'b00))
        else $error("result handle not word aligned");

    a_err_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != sbba_pkg::S_APPLY) |=> (chk_err_reg == $past(chk_err_reg)))
        else $error("check error count moved outside descriptor check");
`endif

endmodule

### verif/size_binned_block_allocator_top_test.sv
// Self-checking testbench for size_binned_block_allocator_top: directed rows, then
// randomized allocate/free traffic over several pool settings, checked by a local predictor.
// Depends on sbba_pkg and the allocator RTL.
module size_binned_block_allocator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HANDLE_W       = sbba_pkg::HANDLE_W;
    localparam int SIZE_W         = sbba_pkg::SIZE_W;
    localparam int COUNT_W        = sbba_pkg::COUNT_W;
    localparam int CFG_IDX_W      = sbba_pkg::CFG_IDX_W;
    localparam int MAX_BINS       = sbba_pkg::MAX_BINS;

    localparam int NUM_BINS       = 6;
    localparam int POOL_BYTES     = 4096;
    localparam int DESC_BYTES     = 20;
    localparam int VALIDITY_BYTES = 4;
    localparam int DESC_SPAN      = (DESC_BYTES + 3) / 4 * 4;
    localparam int POOL_LIMIT     = POOL_BYTES < sbba_pkg::HANDLE_REACH ?
                                    POOL_BYTES : sbba_pkg::HANDLE_REACH;
    localparam int STORE_DEPTH    = POOL_BYTES / 4;

    localparam logic                 REQ_FREE = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN0 = 3'd0;

    typedef struct {
        bit                   cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [SIZE_W-1:0]    val;
        sbba_pkg::req_t       r;
        bit                   typed;
        sbba_pkg::rsp_t       want;
    } row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_ready;
    sbba_pkg::req_t       req;
    logic                 rsp_valid;
    logic                 rsp_ready;
    sbba_pkg::rsp_t       rsp;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [SIZE_W-1:0]    cfg_wdata;

    size_binned_block_allocator_top #(
        .NUM_BINS       (NUM_BINS),
        .POOL_BYTES     (POOL_BYTES),
        .DESC_BYTES     (DESC_BYTES),
        .VALIDITY_BYTES (VALIDITY_BYTES)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // allocator shadow state
    logic [SIZE_W-1:0]   bin_sz [MAX_BINS];
    logic [HANDLE_W-1:0] start_reg;
    logic [SIZE_W-1:0]   size_reg;
    bit                  dsc_valid [STORE_DEPTH];
    bit                  dsc_used [STORE_DEPTH];
    logic [15:0]         dsc_size [STORE_DEPTH];
    logic [15:0]         dsc_next [STORE_DEPTH];
    logic [HANDLE_W-1:0] stack_top [MAX_BINS];
    logic [HANDLE_W-1:0] fresh_ptr;
    logic [15:0]         carved [MAX_BINS];
    logic [COUNT_W-1:0]  bad_size_cnt;

    sbba_pkg::rsp_t      pending_rsp [$];
    logic [HANDLE_W-1:0] live [$];
    logic [HANDLE_W-1:0] freed [$];
    row_t                plan [$];

    bit quiet;
    int mismatches;
    int n_checked;
    int n_granted;
    int n_released;
    int n_rejected;
    int n_carved;

    function automatic int pool_end();
        int e;
        e = int'(start_reg) + int'(size_reg);
        return e > POOL_LIMIT ? POOL_LIMIT : e;
    endfunction

    function automatic int pick_bin(int want);
        int i;
        if (want > int'(bin_sz[0]))
            return -1;
        i = 0;
        while (i < NUM_BINS - 1 && want <= int'(bin_sz[i + 1]))
            i++;
        return i;
    endfunction

    function automatic sbba_pkg::rsp_t serve_request(sbba_pkg::req_t r);
        sbba_pkg::rsp_t o;
        int   b;
        int   ix;
        int   h;
        int   upper;
        o = '0;
        o.status = sbba_pkg::STS_OK;
        if (r.req_type == sbba_pkg::REQ_ALLOC)
        begin
            b = pick_bin(int'(r.req_size));
            if (b < 0)
            begin
                o.status = sbba_pkg::STS_NO_ROOM;
            end
            else if (stack_top[b] != 0)
            begin
                h = int'(stack_top[b]);
                ix = (h >> 2) % STORE_DEPTH;
                stack_top[b] = dsc_next[ix][HANDLE_W-1:0];
                dsc_valid[ix] = 1'b1;
                dsc_used[ix] = 1'b1;
                dsc_size[ix] = 16'(bin_sz[b]);
                dsc_next[ix] = '0;
                o.block_handle = h[HANDLE_W-1:0];
                o.granted_size = bin_sz[b];
            end
            else if (fresh_ptr == 0 ||
                     int'(fresh_ptr) + DESC_SPAN + int'(bin_sz[b]) >= pool_end())
            begin
                o.status = sbba_pkg::STS_NO_ROOM;
            end
            else
            begin
                h = int'(fresh_ptr);
                ix = (h >> 2) % STORE_DEPTH;
                carved[b] = carved[b] + 16'd1;
                dsc_valid[ix] = 1'b1;
                dsc_used[ix] = 1'b1;
                dsc_size[ix] = 16'(bin_sz[b]);
                dsc_next[ix] = '0;
                fresh_ptr = HANDLE_W'(h + int'(bin_sz[b]) + DESC_SPAN);
                o.block_handle = h[HANDLE_W-1:0];
                o.granted_size = bin_sz[b];
                n_carved++;
            end
        end
        else
        begin
            h = int'(r.free_handle);
            upper = pool_end() - DESC_SPAN - int'(bin_sz[NUM_BINS-1]) - VALIDITY_BYTES;
            if (h % 4 != 0 || h < VALIDITY_BYTES || h > upper)
            begin
                o.status = sbba_pkg::STS_BAD_HANDLE;
            end
            else
            begin
                ix = (h >> 2) % STORE_DEPTH;
                if (!dsc_valid[ix] || !dsc_used[ix])
                begin
                    o.status = sbba_pkg::STS_BAD_HANDLE;
                end
                else
                begin
                    b = pick_bin(int'(dsc_size[ix]));
                    if (b < 0)
                    begin
                        if (bad_size_cnt != 16'hffff)
                            bad_size_cnt = bad_size_cnt + 16'd1;
                        o.status = sbba_pkg::STS_BAD_HANDLE;
                    end
                    else
                    begin
                        dsc_next[ix] = 16'(stack_top[b]);
                        dsc_used[ix] = 1'b0;
                        stack_top[b] = h[HANDLE_W-1:0];
                    end
                end
            end
        end
        o.check_errors = bad_size_cnt;
        return o;
    endfunction

    function automatic row_t mk_req(logic kind, logic [SIZE_W-1:0] sz,
                                    logic [HANDLE_W-1:0] hd);
        row_t w;
        w.cfg = 1'b0;
        w.idx = '0;
        w.val = '0;
        w.r.req_type = kind;
        w.r.req_size = sz;
        w.r.free_handle = hd;
        w.typed = 1'b0;
        w.want = '0;
        return w;
    endfunction

    function automatic row_t mk_chk(logic kind, logic [SIZE_W-1:0] sz,
                                    logic [HANDLE_W-1:0] hd, sbba_pkg::status_t st,
                                    logic [HANDLE_W-1:0] bh, logic [SIZE_W-1:0] gs,
                                    logic [COUNT_W-1:0] ce);
        row_t w;
        w = mk_req(kind, sz, hd);
        w.typed = 1'b1;
        w.want.status = st;
        w.want.block_handle = bh;
        w.want.granted_size = gs;
        w.want.check_errors = ce;
        return w;
    endfunction

    function automatic row_t mk_cfg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
        row_t w;
        w = mk_req(sbba_pkg::REQ_ALLOC, '0, '0);
        w.cfg = 1'b1;
        w.idx = idx;
        w.val = val;
        return w;
    endfunction

    function automatic sbba_pkg::req_t gen_item();
        sbba_pkg::req_t r;
        int   pick;
        int   k;
        int   alloc_pct;
        r.req_size = SIZE_W'($urandom);
        r.free_handle = HANDLE_W'($urandom);
        alloc_pct = live.size() < 4 ? 80 : (live.size() > 48 ? 25 : 55);
        if ($urandom_range(0, 99) < alloc_pct)
        begin
            r.req_type = sbba_pkg::REQ_ALLOC;
            pick = $urandom_range(0, 9);
            if (pick < 5)
            begin
                r.req_size = SIZE_W'($urandom_range(0, 64));
            end
            else if (pick < 7)
            begin
                k = $urandom_range(0, NUM_BINS - 1);
                r.req_size = bin_sz[k] + SIZE_W'($urandom_range(0, 2)) - 12'd1;
            end
            else if (pick < 9)
            begin
                r.req_size = SIZE_W'($urandom_range(0, int'(bin_sz[0]) + 8));
            end
        end
        else
        begin
            r.req_type = REQ_FREE;
            pick = $urandom_range(0, 9);
            if (pick < 6 && live.size() > 0)
            begin
                k = $urandom_range(0, live.size() - 1);
                r.free_handle = live[k];
                live.delete(k);
                freed.push_back(r.free_handle);
                if (freed.size() > 32)
                    freed.delete(0);
            end
            else if (pick < 7 && freed.size() > 0)
            begin
                r.free_handle = freed[$urandom_range(0, freed.size() - 1)];
            end
            else if (pick < 9)
            begin
                r.free_handle = {10'($urandom), 2'b00};
            end
        end
        return r;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    task automatic send_req(input sbba_pkg::req_t r, input bit typed,
                            input sbba_pkg::rsp_t want);
        sbba_pkg::rsp_t o;
        int   gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (!req_ready);
        o = serve_request(r);
        pending_rsp.push_back(typed ? want : o);
        if (o.status != sbba_pkg::STS_OK)
            n_rejected++;
        else if (r.req_type == sbba_pkg::REQ_ALLOC)
        begin
            n_granted++;
            live.push_back(o.block_handle);
        end
        else
            n_released++;
    endtask

    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
        logic [SIZE_W-1:0] v;
        v = val & 12'hffc;
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        if (idx < MAX_BINS)
            bin_sz[idx] = v;
        else if (idx == sbba_pkg::CFG_POOL_START)
        begin
            start_reg = v;
            fresh_ptr = v;
        end
        else if (idx == sbba_pkg::CFG_POOL_SIZE)
            size_reg = v;
    endtask

    // vals: pool_size in the top slice down to bin 0 in the bottom slice
    task automatic run_phase(input logic [8*SIZE_W-1:0] vals, input int n_items,
                             input bit calm);
        drain();
        for (int i = 0; i < 8; i++)
            write_reg(CFG_IDX_W'(i), vals[i*SIZE_W +: SIZE_W]);
        @(negedge clk);
        cfg_we <= 1'b0;
        quiet = calm;
        repeat (n_items)
            send_req(gen_item(), 1'b0, '0);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        int stall;
        stall = 0;
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                stall--;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall = $urandom_range(1, 12) - 1;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        sbba_pkg::rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
                note_mismatch($sformatf("response %h with nothing pending", rsp));
            else
            begin
                want = pending_rsp.pop_front();
                n_checked++;
                if (rsp.status !== want.status)
                    note_mismatch($sformatf("status got %0d want %0d",
                                            rsp.status, want.status));
                if (rsp.block_handle !== want.block_handle)
                    note_mismatch($sformatf("block_handle got %0d want %0d",
                                            rsp.block_handle, want.block_handle));
                if (rsp.granted_size !== want.granted_size)
                    note_mismatch($sformatf("granted_size got %0d want %0d",
                                            rsp.granted_size, want.granted_size));
                if (rsp.check_errors !== want.check_errors)
                    note_mismatch($sformatf("check_errors got %0d want %0d",
                                            rsp.check_errors, want.check_errors));
            end
        end
    end

    initial
    begin
        #2000000;
        $display("timeout with %0d responses outstanding", pending_rsp.size());
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        quiet = 1'b0;
        mismatches = 0;
        n_checked = 0;
        n_granted = 0;
        n_released = 0;
        n_rejected = 0;
        n_carved = 0;
        for (int i = 0; i < MAX_BINS; i++)
        begin
            bin_sz[i] = sbba_pkg::BIN_RESET[i];
            stack_top[i] = '0;
            carved[i] = '0;
        end
        for (int k = 0; k < STORE_DEPTH; k++)
        begin
            dsc_valid[k] = 1'b0;
            dsc_used[k] = 1'b0;
            dsc_size[k] = '0;
            dsc_next[k] = '0;
        end
        start_reg = sbba_pkg::POOL_START_RESET;
        size_reg = sbba_pkg::POOL_SIZE_RESET;
        fresh_ptr = sbba_pkg::POOL_START_RESET;
        bad_size_cnt = '0;

        plan.push_back(mk_chk(REQ_FREE, 12'hfff, 12'd0, sbba_pkg::STS_BAD_HANDLE,
                              '0, '0, '0));
        plan.push_back(mk_chk(REQ_FREE, 12'd0, 12'd3, sbba_pkg::STS_BAD_HANDLE,
                              '0, '0, '0));
        plan.push_back(mk_chk(REQ_FREE, 12'd0, 12'hfff, sbba_pkg::STS_BAD_HANDLE,
                              '0, '0, '0));
        plan.push_back(mk_chk(REQ_FREE, 12'd0, 12'd4, sbba_pkg::STS_BAD_HANDLE,
                              '0, '0, '0));
        plan.push_back(mk_chk(REQ_FREE, 12'd0, 12'd4044, sbba_pkg::STS_BAD_HANDLE,
                              '0, '0, '0));
        plan.push_back(mk_chk(sbba_pkg::REQ_ALLOC, 12'hfff, 12'hfff, sbba_pkg::STS_NO_ROOM,
                              '0, '0, '0));
        plan.push_back(mk_chk(sbba_pkg::REQ_ALLOC, 12'd1025, 12'd0, sbba_pkg::STS_NO_ROOM,
                              '0, '0, '0));
        plan.push_back(mk_chk(sbba_pkg::REQ_ALLOC, 12'd0, 12'hfff, sbba_pkg::STS_OK,
                              12'd4, 12'd32, '0));
        plan.push_back(mk_chk(sbba_pkg::REQ_ALLOC, 12'd1024, 12'd0, sbba_pkg::STS_OK,
                              12'd56, 12'd1024, '0));
        plan.push_back(mk_req(sbba_pkg::REQ_ALLOC, 12'd33, 12'd0));
        plan.push_back(mk_req(REQ_FREE, 12'd0, 12'd4));
        plan.push_back(mk_req(REQ_FREE, 12'd0, 12'd4));
        plan.push_back(mk_req(sbba_pkg::REQ_ALLOC, 12'd32, 12'd0));
        plan.push_back(mk_req(REQ_FREE, 12'd0, 12'd56));
        plan.push_back(mk_req(REQ_FREE, 12'd0, 12'd1100));
        plan.push_back(mk_req(sbba_pkg::REQ_ALLOC, 12'd1000, 12'd0));
        plan.push_back(mk_req(sbba_pkg::REQ_ALLOC, 12'd512, 12'd0));
        plan.push_back(mk_req(sbba_pkg::REQ_ALLOC, 12'd1024, 12'd0));
        plan.push_back(mk_req(sbba_pkg::REQ_ALLOC, 12'd1024, 12'd0));
        plan.push_back(mk_req(sbba_pkg::REQ_ALLOC, 12'd1024, 12'd0));
        plan.push_back(mk_req(sbba_pkg::REQ_ALLOC, 12'd1, 12'd0));
        plan.push_back(mk_req(REQ_FREE, 12'd0, 12'd4040));
        plan.push_back(mk_cfg(CFG_BIN0, 12'd512));
        plan.push_back(mk_chk(REQ_FREE, 12'd0, 12'd1716, sbba_pkg::STS_BAD_HANDLE,
                              '0, '0, 16'd1));
        plan.push_back(mk_req(REQ_FREE, 12'd0, 12'd2760));
        plan.push_back(mk_cfg(CFG_BIN0, 12'd1024));

        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].cfg)
            begin
                drain();
                write_reg(plan[i].idx, plan[i].val);
                @(negedge clk);
                cfg_we <= 1'b0;
            end
            else
                send_req(plan[i].r, plan[i].typed, plan[i].want);
        end

        run_phase({12'd4092, 12'd4, 12'd32, 12'd64, 12'd128, 12'd256, 12'd512, 12'd1024},
                  250, 1'b0);
        run_phase({12'd900, 12'd100, 12'd8, 12'd16, 12'd32, 12'd64, 12'd128, 12'd256},
                  250, 1'b0);
        run_phase({12'd0, 12'd4095, 12'd4, 12'd8, 12'd512, 12'd1024, 12'd2048, 12'd4095},
                  250, 1'b0);
        run_phase({12'd4095, 12'd0, 12'd0, 12'd32, 12'd36, 12'd40, 12'd48, 12'd64},
                  250, 1'b0);
        run_phase({12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                   12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom)},
                  250, 1'b0);
        run_phase({12'd2000, 12'd8, 12'd16, 12'd32, 12'd64, 12'd128, 12'd256, 12'd512},
                  250, 1'b1);

        drain();
        repeat (10) @(negedge clk);

        $display("checked %0d responses: %0d blocks granted (%0d carved fresh), %0d freed",
                 n_checked, n_granted, n_carved, n_released);
        $display("%0d requests rejected, %0d oversized descriptors seen, %0d mismatches",
                 n_rejected, bad_size_cnt, mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/sbba_pkg.sv
hw/rtl/sbba_desc_mem.sv
hw/rtl/size_binned_block_allocator_top.sv
verif/size_binned_block_allocator_top_test.sv
